// File: sv/flsp_pkg.sv
// Shared types, constants and register codes for the local score peak finder.
package flsp_pkg;

   // Defaults for the top level parameters
   localparam int HALF_SIZE_DEFAULT  = 2;
   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int SCORE_BITS_DEFAULT = 16;

   // Fixed field widths and limits
   localparam int COORD_BITS     = 10;
   localparam int DIM_BITS       = 11;
   localparam int INDEX_BITS     = 16;
   localparam int OUT_SCORE_BITS = 16;
   localparam int COORD_LIMIT    = 1024;
   localparam int WIDTH_RESET    = 640;
   localparam int HEIGHT_RESET   = 480;
   localparam int CSR_INDEX_BITS = 1;

   typedef logic [COORD_BITS-1:0]            coord_type;
   typedef logic [DIM_BITS-1:0]              dim_type;
   typedef logic [INDEX_BITS-1:0]            index_type;
   typedef logic signed [OUT_SCORE_BITS-1:0] out_score_type;

   localparam index_type INDEX_MAX = '1;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // Candidate control that travels with a pixel into the compare stage
   typedef struct packed {
      logic      valid;
      logic      sof;
      logic      in_range;
      coord_type x;
      coord_type y;
   } cand_type;

   // One detected peak
   typedef struct packed {
      coord_type     peak_x;
      coord_type     peak_y;
      out_score_type peak_score;
      index_type     peak_index;
   } result_type;

endpackage

// File: sv/find_local_score_peaks_unit.sv
// Top level: streams score and mask pixels and reports local score peaks.
// Throughput: one pixel per clock while the queue has room, set by one read and one write of
// the line buffer per pixel. A peak is found at the pixel HALF_SIZE columns and rows past it.
// Results pass a two-entry queue; req_ready drops only while that queue is full.
// Reset (synchronous, active high) clears position, peak count, pipeline and queue and
// loads the size registers; line buffer contents stay undefined until rows are written.
module find_local_score_peaks_unit #(
   parameter int HALF_SIZE  = flsp_pkg::HALF_SIZE_DEFAULT,
   parameter int MAX_WIDTH  = flsp_pkg::MAX_WIDTH_DEFAULT,
   parameter int SCORE_BITS = flsp_pkg::SCORE_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [flsp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  flsp_pkg::dim_type                     csr_write_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [15:0]                    req_pixel_score,
   input  logic                                  req_pixel_mask,
   input  logic                                  req_start_of_frame,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output flsp_pkg::coord_type                   rsp_peak_x,
   output flsp_pkg::coord_type                   rsp_peak_y,
   output flsp_pkg::out_score_type               rsp_peak_score,
   output flsp_pkg::index_type                   rsp_peak_index
);

   localparam int WIN        = 2 * HALF_SIZE + 1;
   localparam int LINE_DEPTH = (MAX_WIDTH < flsp_pkg::COORD_LIMIT) ? MAX_WIDTH
                                                                   : flsp_pkg::COORD_LIMIT;
   localparam int ADDR_BITS  = $clog2(LINE_DEPTH);
   localparam int MASK_BASE  = 2 * HALF_SIZE * SCORE_BITS;
   localparam int WORD_BITS  = MASK_BASE + HALF_SIZE;
   localparam int WIDTH_RST  = (flsp_pkg::WIDTH_RESET < LINE_DEPTH) ? flsp_pkg::WIDTH_RESET
                                                                    : LINE_DEPTH;

   localparam flsp_pkg::dim_type   WIDTH_LIMIT  = flsp_pkg::dim_type'(LINE_DEPTH);
   localparam flsp_pkg::dim_type   HEIGHT_LIMIT = flsp_pkg::dim_type'(flsp_pkg::COORD_LIMIT);
   localparam flsp_pkg::dim_type   WIDTH_INIT   = flsp_pkg::dim_type'(WIDTH_RST);
   localparam flsp_pkg::dim_type   HEIGHT_INIT  = flsp_pkg::dim_type'(flsp_pkg::HEIGHT_RESET);
   localparam flsp_pkg::coord_type LOW_EDGE     = flsp_pkg::coord_type'(HALF_SIZE + WIN);
   localparam flsp_pkg::dim_type   HIGH_OFFSET  = flsp_pkg::dim_type'(2 * WIN - HALF_SIZE);
   localparam flsp_pkg::coord_type HALF_OFFSET  = flsp_pkg::coord_type'(HALF_SIZE);

   flsp_pkg::dim_type   width_ff, width_in;
   flsp_pkg::dim_type   height_ff, height_in;
   flsp_pkg::dim_type   csr_width, csr_height;

   flsp_pkg::coord_type col_ff, col_in;
   flsp_pkg::coord_type row_ff, row_in;
   flsp_pkg::coord_type col_base, row_base;
   flsp_pkg::coord_type pos_col, pos_row;
   flsp_pkg::dim_type   row_step, col_next, row_next;

   logic                    req_accept;
   logic                    advance;
   logic [SCORE_BITS-1:0]   score_ext;

   logic                    s1_valid_ff;
   logic [SCORE_BITS-1:0]   s1_score_ff;
   logic                    s1_mask_ff;
   logic                    s1_sof_ff;
   flsp_pkg::coord_type     s1_col_ff;
   flsp_pkg::coord_type     s1_row_ff;

   logic [WORD_BITS-1:0]        rd_data;
   logic [WORD_BITS-1:0]        wr_data;
   logic [WIN*SCORE_BITS-1:0]   new_col;
   logic                        new_mask;
   logic                        shift_en;
   logic                        x_ok, y_ok;
   flsp_pkg::cand_type          cand;
   logic                        push;
   flsp_pkg::result_type        push_data;
   flsp_pkg::result_type        out_data;

   // Clamp size writes to the supported range
   always_comb begin
      if (csr_write_data == '0) begin
         csr_width = flsp_pkg::dim_type'(1);
      end else if (csr_write_data > WIDTH_LIMIT) begin
         csr_width = WIDTH_LIMIT;
      end else begin
         csr_width = csr_write_data;
      end
      if (csr_write_data == '0) begin
         csr_height = flsp_pkg::dim_type'(1);
      end else if (csr_write_data > HEIGHT_LIMIT) begin
         csr_height = HEIGHT_LIMIT;
      end else begin
         csr_height = csr_write_data;
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_enable) begin
         case (csr_index)
            flsp_pkg::CSR_IMAGE_WIDTH: begin
               width_in = csr_width;
            end
            flsp_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = csr_height;
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_INIT;
         height_ff <= HEIGHT_INIT;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Handshake: the pipeline moves while the result queue has room
   assign req_ready  = advance;
   assign req_accept = req_valid && req_ready;

   // Truncate the two's complement score to SCORE_BITS, or zero-extend it if SCORE_BITS > 16
   if (SCORE_BITS <= 16) begin : g_score_narrow
      assign score_ext = req_pixel_score[SCORE_BITS-1:0];
   end else begin : g_score_wide
      assign score_ext = {{(SCORE_BITS-16){1'b0}}, req_pixel_score};
   end

   // Place the incoming pixel and step the raster position
   always_comb begin
      col_base = req_start_of_frame ? '0 : col_ff;
      row_base = req_start_of_frame ? '0 : row_ff;
      if ({1'b0, col_base} >= width_ff) begin
         pos_col  = '0;
         row_step = {1'b0, row_base} + flsp_pkg::dim_type'(1);
      end else begin
         pos_col  = col_base;
         row_step = {1'b0, row_base};
      end
      pos_row  = (row_step >= height_ff) ? '0 : row_step[flsp_pkg::COORD_BITS-1:0];
      col_next = {1'b0, pos_col} + flsp_pkg::dim_type'(1);
      row_next = {1'b0, pos_row} + flsp_pkg::dim_type'(1);
      if (col_next >= width_ff) begin
         col_in = '0;
         row_in = (row_next >= height_ff) ? '0 : row_next[flsp_pkg::COORD_BITS-1:0];
      end else begin
         col_in = col_next[flsp_pkg::COORD_BITS-1:0];
         row_in = pos_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Input register stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_score_ff <= score_ext;
         s1_mask_ff  <= req_pixel_mask;
         s1_sof_ff   <= req_start_of_frame;
         s1_col_ff   <= pos_col;
         s1_row_ff   <= pos_row;
      end
   end

   // Line buffer: one word per column holding the rows above the current one
   flsp_line_buffer #(
      .DEPTH     (LINE_DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_line_buffer (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (pos_col[ADDR_BITS-1:0]),
      .rd_data (rd_data),
      .wr_en   (shift_en),
      .wr_addr (s1_col_ff[ADDR_BITS-1:0]),
      .wr_data (wr_data)
   );

   assign shift_en = s1_valid_ff && advance;

   // Push the new pixel into the column and drop the oldest row
   always_comb begin
      new_col                      = '0;
      wr_data                      = '0;
      new_col[0 +: SCORE_BITS]     = s1_score_ff;
      wr_data[0 +: SCORE_BITS]     = s1_score_ff;
      wr_data[MASK_BASE]           = s1_mask_ff;
      for (int k = 1; k < WIN; k++) begin
         new_col[k*SCORE_BITS +: SCORE_BITS] = rd_data[(k-1)*SCORE_BITS +: SCORE_BITS];
      end
      for (int k = 1; k < WIN - 1; k++) begin
         wr_data[k*SCORE_BITS +: SCORE_BITS] = rd_data[(k-1)*SCORE_BITS +: SCORE_BITS];
      end
      for (int k = 1; k < HALF_SIZE; k++) begin
         wr_data[MASK_BASE + k] = rd_data[MASK_BASE + k - 1];
      end
   end

   assign new_mask = rd_data[MASK_BASE + HALF_SIZE - 1];

   // Check that the candidate lies inside the margins
   assign x_ok = (s1_col_ff >= LOW_EDGE) && (({1'b0, s1_col_ff} + HIGH_OFFSET) < width_ff);
   assign y_ok = (s1_row_ff >= LOW_EDGE) && (({1'b0, s1_row_ff} + HIGH_OFFSET) < height_ff);

   assign cand.valid    = s1_valid_ff;
   assign cand.sof      = s1_sof_ff;
   assign cand.in_range = x_ok && y_ok;
   assign cand.x        = s1_col_ff - HALF_OFFSET;
   assign cand.y        = s1_row_ff - HALF_OFFSET;

   flsp_peak_window #(
      .HALF_SIZE  (HALF_SIZE),
      .SCORE_BITS (SCORE_BITS)
   ) u_peak_window (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .shift_en (shift_en),
      .new_col  (new_col),
      .new_mask (new_mask),
      .cand     (cand),
      .push     (push),
      .result   (push_data)
   );

   flsp_result_queue u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop_ready (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .has_room  (advance)
   );

   assign rsp_peak_x     = out_data.peak_x;
   assign rsp_peak_y     = out_data.peak_y;
   assign rsp_peak_score = out_data.peak_score;
   assign rsp_peak_index = out_data.peak_index;

endmodule

// File: sv/flsp_line_buffer.sv
// Line buffer memory: one read and one write port, registered read data.
module flsp_line_buffer #(
   parameter int DEPTH     = flsp_pkg::MAX_WIDTH_DEFAULT,
   parameter int WORD_BITS = 4 * flsp_pkg::SCORE_BITS_DEFAULT + 2,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WORD_BITS-1:0] rd_data,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WORD_BITS-1:0] wr_data
);

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   // Write the updated column word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read the column word of the incoming pixel
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/flsp_peak_window.sv
// Score window registers, peak compare and running peak index.
module flsp_peak_window #(
   parameter int HALF_SIZE  = flsp_pkg::HALF_SIZE_DEFAULT,
   parameter int SCORE_BITS = flsp_pkg::SCORE_BITS_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        advance,
   input  logic                                        shift_en,
   input  logic [(2*HALF_SIZE+1)*SCORE_BITS-1:0]       new_col,
   input  logic                                        new_mask,
   input  flsp_pkg::cand_type                          cand,
   output logic                                        push,
   output flsp_pkg::result_type                        result
);

   localparam int WIN = 2 * HALF_SIZE + 1;

   logic signed [SCORE_BITS-1:0] win_ff [WIN][WIN];
   logic [HALF_SIZE:0]           mask_tap_ff;
   flsp_pkg::cand_type           cand_ff;
   flsp_pkg::index_type          peaks_ff;
   flsp_pkg::index_type          peaks_in;
   flsp_pkg::index_type          peak_base;
   logic signed [SCORE_BITS-1:0] center;
   flsp_pkg::out_score_type      center_out;
   logic                         greater;
   logic                         peak;

   // Shift the window one column left and load the new column on the right
   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int i = 0; i < WIN; i++) begin
            for (int j = 0; j < WIN - 1; j++) begin
               win_ff[i][j] <= win_ff[i][j+1];
            end
            win_ff[i][WIN-1] <= new_col[i*SCORE_BITS +: SCORE_BITS];
         end
         mask_tap_ff <= {new_mask, mask_tap_ff[HALF_SIZE:1]};
      end
   end

   // Hold or advance the candidate control
   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff.valid <= 1'b0;
      end else if (advance) begin
         cand_ff <= cand;
      end
   end

   // Compare every window entry against the center
   assign center = win_ff[HALF_SIZE][HALF_SIZE];

   always_comb begin
      greater = 1'b0;
      for (int i = 0; i < WIN; i++) begin
         for (int j = 0; j < WIN; j++) begin
            if (win_ff[i][j] > center) begin
               greater = 1'b1;
            end
         end
      end
   end

   assign peak = cand_ff.valid && cand_ff.in_range && mask_tap_ff[0]
                 && (center != '0) && !greater;

   // Bring the center score to the output field width
   if (SCORE_BITS >= flsp_pkg::OUT_SCORE_BITS) begin : g_score_trunc
      assign center_out = center[flsp_pkg::OUT_SCORE_BITS-1:0];
   end else begin : g_score_ext
      assign center_out = {{(flsp_pkg::OUT_SCORE_BITS-SCORE_BITS){center[SCORE_BITS-1]}},
                           center};
   end

   // Clear the count on start of frame, then count peaks with saturation
   always_comb begin
      peak_base = cand_ff.sof ? '0 : peaks_ff;
      peaks_in  = peaks_ff;
      if (cand_ff.valid) begin
         if (peak && (peak_base != flsp_pkg::INDEX_MAX)) begin
            peaks_in = peak_base + flsp_pkg::index_type'(1);
         end else begin
            peaks_in = peak_base;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peaks_ff <= '0;
      end else if (advance) begin
         peaks_ff <= peaks_in;
      end
   end

   assign push              = peak && advance;
   assign result.peak_x     = cand_ff.x;
   assign result.peak_y     = cand_ff.y;
   assign result.peak_score = center_out;
   assign result.peak_index = peak_base;

endmodule

// File: sv/flsp_result_queue.sv
// Two-entry result queue that decouples the pipeline from the consumer.
module flsp_result_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  flsp_pkg::result_type push_data,
   input  logic                 pop_ready,
   output logic                 out_valid,
   output flsp_pkg::result_type out_data,
   output logic                 has_room
);

   localparam logic [1:0] FULL_COUNT = 2'd2;

   flsp_pkg::result_type entry_ff [2];
   logic                 wr_ptr_ff;
   logic                 rd_ptr_ff;
   logic [1:0]           count_ff;
   logic [1:0]           count_in;
   logic                 pop;

   assign out_valid = count_ff != 2'd0;
   assign has_room  = count_ff != FULL_COUNT;
   assign pop       = out_valid && pop_ready;
   assign out_data  = entry_ff[rd_ptr_ff];

   // Track occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   // Store a new result
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/flsp_checker.sv
// Port-level assertions for the peak finder and the bind that attaches them.
module flsp_checker #(
   parameter int HALF_SIZE = flsp_pkg::HALF_SIZE_DEFAULT
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input flsp_pkg::coord_type     rsp_peak_x,
   input flsp_pkg::coord_type     rsp_peak_y,
   input flsp_pkg::out_score_type rsp_peak_score,
   input flsp_pkg::index_type     rsp_peak_index
);

   localparam flsp_pkg::coord_type MARGIN = flsp_pkg::coord_type'(2 * HALF_SIZE + 1);

   // Reset empties the result queue
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending right after reset");

   // A stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_peak_x) && $stable(rsp_peak_y)
                                  && $stable(rsp_peak_score) && $stable(rsp_peak_index))
      else $error("stalled result changed");

   // A zero score is never a peak
   a_score_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_peak_score != '0)
      else $error("peak reported with zero score");

   // Peaks lie past the leading margins
   a_margin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_peak_x >= MARGIN) && (rsp_peak_y >= MARGIN))
      else $error("peak reported inside the margin");

endmodule

bind find_local_score_peaks_unit flsp_checker #(.HALF_SIZE(HALF_SIZE)) u_flsp_checker (.*);
